// ----- rtl/slap_pkg.sv -----
// Shared types, constants and functions of the servo linkage angle-to-pulse block.
`default_nettype none
package slap_pkg;

    localparam int TABLE_LEN         = 24;
    localparam int CORDIC_STAGES_DEF = 16;

    localparam int ZW     = 34;  // angle in Q30 radians
    localparam int XW     = 32;  // CORDIC coordinate in Q16 mm
    localparam int DW     = 28;  // offset to the servo pivot in Q16 mm
    localparam int SQ_W   = 54;  // squared distance
    localparam int NUMW   = 40;  // cosine numerator
    localparam int DENW   = 34;  // cosine denominator
    localparam int CW     = 26;  // cosine in Q24
    localparam int QW     = 25;  // divider quotient bits
    localparam int SIN_W  = 50;  // input of the sine root
    localparam int CFG_IW = 2;

    typedef enum logic [CFG_IW-1:0] {
        REG_X_GAIN     = 2'd0,
        REG_Y_GAIN     = 2'd1,
        REG_TILT_LIMIT = 2'd2
    } t_reg_idx;

    localparam logic [15:0] X_GAIN_RST     = 16'd1812;
    localparam logic [15:0] Y_GAIN_RST     = 16'd1945;
    localparam logic [14:0] TILT_LIMIT_RST = 15'd1280;

    localparam logic signed [ZW-1:0] HALF_PI_Q30 = 34'sd1686629713;
    localparam logic signed [40:0]   DEG2RAD_Q30 = 41'sd18740330;
    localparam logic signed [57:0]   RAD2DEG_Q16 = 58'sd3754936;
    localparam logic signed [46:0]   CENTER_Q24  = 47'sd1500 <<< 24;
    localparam logic [21:0]          TWO_L3      = 22'd2883584;
    localparam logic [QW-1:0]        COS_ONE     = 25'd16777216;
    localparam logic [SIN_W-1:0]     ONE_SQ      = 50'd1 << 48;

    localparam longint KINV_Q30 = 64'sd652032874;
    localparam longint R_X = (64'sd16957440 * KINV_Q30) >>> 30;
    localparam longint R_Y = (64'sd16924672 * KINV_Q30) >>> 30;
    localparam longint L3SQ = 64'sd1441792 * 64'sd1441792;
    localparam longint NUMK_X = L3SQ - 64'sd3637248 * 64'sd3637248;
    localparam longint NUMK_Y = L3SQ - 64'sd3604480 * 64'sd3604480;

    // Payload that rides alongside the arithmetic through the pipeline.
    typedef struct packed {
        logic                   ax;
        logic [15:0]            gain;
        logic signed [DW-1:0]   dx;
        logic signed [DW-1:0]   dy;
        logic signed [NUMW-1:0] num;
        logic signed [CW-1:0]   c;
    } t_side;

    function automatic logic signed [ZW-1:0] atan_q30(input int i);
        logic signed [ZW-1:0] v;
        case (i)
            0:       v = 34'sd843314856;
            1:       v = 34'sd497837829;
            2:       v = 34'sd263043836;
            3:       v = 34'sd133525158;
            4:       v = 34'sd67021686;
            5:       v = 34'sd33543515;
            6:       v = 34'sd16775850;
            7:       v = 34'sd8388437;
            8:       v = 34'sd4194282;
            9:       v = 34'sd2097149;
            10:      v = 34'sd1048575;
            11:      v = 34'sd524287;
            12:      v = 34'sd262143;
            13:      v = 34'sd131071;
            14:      v = 34'sd65535;
            15:      v = 34'sd32767;
            16:      v = 34'sd16383;
            17:      v = 34'sd8191;
            18:      v = 34'sd4095;
            19:      v = 34'sd2047;
            20:      v = 34'sd1023;
            21:      v = 34'sd511;
            22:      v = 34'sd255;
            23:      v = 34'sd127;
            default: v = '0;
        endcase
        return v;
    endfunction

    function automatic logic signed [ZW-1:0] alpha0(input logic ax);
        return ax ? 34'sd77009640 : 34'sd80922620;
    endfunction

    function automatic logic signed [XW-1:0] rot_start(input logic ax);
        return ax ? XW'(R_Y) : XW'(R_X);
    endfunction

    function automatic logic signed [XW-1:0] pivot_x(input logic ax);
        return ax ? 32'sd18350080 : 32'sd18317312;
    endfunction

    function automatic logic signed [XW-1:0] pivot_y(input logic ax);
        return ax ? -32'sd2392064 : -32'sd2555904;
    endfunction

    function automatic logic signed [55:0] num_k(input logic ax);
        return ax ? 56'(NUMK_Y) : 56'(NUMK_X);
    endfunction

endpackage
`default_nettype wire

// ----- rtl/slap_if.sv -----
// Handshake channel interfaces for commands, results and register writes.
`default_nettype none
interface slap_cmd_if;
    logic               valid;
    logic               ready;
    logic               opcode;
    logic signed [15:0] tilt_angle;
    modport source (output valid, opcode, tilt_angle, input ready);
    modport sink   (input valid, opcode, tilt_angle, output ready);
endinterface

interface slap_res_if;
    logic        valid;
    logic        ready;
    logic        axis;
    logic [15:0] pulse_width;
    modport source (output valid, axis, pulse_width, input ready);
    modport sink   (input valid, axis, pulse_width, output ready);
endinterface

interface slap_cfg_if import slap_pkg::*;;
    logic              valid;
    logic              ready;
    logic [CFG_IW-1:0] index;
    logic [15:0]       data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ----- rtl/slap_isqrt.sv -----
// Pipelined integer floor square root, one result bit per stage.
`default_nettype none
module slap_isqrt import slap_pkg::*; #(
    parameter int W = SQ_W
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_en,
    input  logic         i_valid,
    input  logic [W-1:0] i_val,
    input  t_side        i_side,
    output logic         o_valid,
    output logic [W/2-1:0] o_root,
    output t_side        o_side
);
    localparam int S = W / 2;

    logic         r_v   [0:S-1];
    logic [W-1:0] r_rem [0:S-1];
    logic [W-1:0] r_res [0:S-1];
    t_side        r_sd  [0:S-1];

    for (genvar k = 0; k < S; k++) begin : g_st
        localparam logic [W-1:0] BIT = W'(1) << (W - 2 - 2 * k);
        logic         cur_v;
        logic [W-1:0] cur_rem, cur_res, trial, n_rem, n_res;
        t_side        cur_sd;

        if (k == 0) begin : g_in
            assign cur_v   = i_valid;
            assign cur_rem = i_val;
            assign cur_res = '0;
            assign cur_sd  = i_side;
        end else begin : g_chain
            assign cur_v   = r_v[k-1];
            assign cur_rem = r_rem[k-1];
            assign cur_res = r_res[k-1];
            assign cur_sd  = r_sd[k-1];
        end

        always_comb begin
            trial = cur_res + BIT;
            if (cur_rem >= trial) begin
                n_rem = cur_rem - trial;
                n_res = (cur_res >> 1) + BIT;
            end else begin
                n_rem = cur_rem;
                n_res = cur_res >> 1;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= cur_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k] <= n_rem;
                r_res[k] <= n_res;
                r_sd[k]  <= cur_sd;
            end
        end
    end

    assign o_valid = r_v[S-1];
    assign o_root  = r_res[S-1][W/2-1:0];
    assign o_side  = r_sd[S-1];
endmodule
`default_nettype wire

// ----- rtl/slap_vec.sv -----
// Pipelined vectoring CORDIC: angle of (x, y) in Q30 radians.
`default_nettype none
module slap_vec import slap_pkg::*; #(
    parameter int N = CORDIC_STAGES_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  logic signed [XW-1:0] i_x,
    input  logic signed [XW-1:0] i_y,
    input  t_side                i_side,
    output logic                 o_valid,
    output logic signed [ZW-1:0] o_z,
    output t_side                o_side
);
    logic                 r_v  [0:N];
    logic signed [XW-1:0] r_x  [0:N];
    logic signed [XW-1:0] r_y  [0:N];
    logic signed [ZW-1:0] r_z  [0:N];
    t_side                r_sd [0:N];

    logic signed [XW-1:0] n_x0, n_y0;
    logic signed [ZW-1:0] n_z0;

    // Left half plane is folded by a quarter turn first.
    always_comb begin
        n_x0 = i_x;
        n_y0 = i_y;
        n_z0 = '0;
        if (i_x < 0) begin
            if (i_y >= 0) begin
                n_x0 = i_y;
                n_y0 = -i_x;
                n_z0 = HALF_PI_Q30;
            end else begin
                n_x0 = -i_y;
                n_y0 = i_x;
                n_z0 = -HALF_PI_Q30;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0]  <= n_x0;
            r_y[0]  <= n_y0;
            r_z[0]  <= n_z0;
            r_sd[0] <= i_side;
        end
    end

    for (genvar k = 0; k < N; k++) begin : g_it
        logic signed [XW-1:0] xs, ys, n_x, n_y;
        logic signed [ZW-1:0] n_z;

        always_comb begin
            xs = r_x[k] >>> k;
            ys = r_y[k] >>> k;
            if (r_y[k] >= 0) begin
                n_x = r_x[k] + ys;
                n_y = r_y[k] - xs;
                n_z = r_z[k] + atan_q30(k);
            end else begin
                n_x = r_x[k] - ys;
                n_y = r_y[k] + xs;
                n_z = r_z[k] - atan_q30(k);
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k+1] <= 1'b0;
            end else if (i_en) begin
                r_v[k+1] <= r_v[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_x[k+1]  <= n_x;
                r_y[k+1]  <= n_y;
                r_z[k+1]  <= n_z;
                r_sd[k+1] <= r_sd[k];
            end
        end
    end

    assign o_valid = r_v[N];
    assign o_z     = r_z[N];
    assign o_side  = r_sd[N];
endmodule
`default_nettype wire

// ----- rtl/servo_linkage_angle_to_pulse_unit.sv -----
// Servo linkage solver: platform tilt request in, servo PWM compare value out.
//
// i_cmd carries one request: an axis select (opcode) and a signed Q7.8 tilt.
// o_res returns one result per request, in order: the axis and the compare
// value, saturated to 0..65535. i_cfg writes the X gain, the Y gain and the
// tilt limit; it is always ready and should only be written while the
// pipeline is empty.
// The rotation and the two vectoring CORDICs take one stage per iteration,
// the distance root 27 stages, the cosine divider 25 and the sine root 25.
// Throughput is one request per cycle while the output is not stalled.
// The whole pipeline advances together whenever the output register is
// empty or being taken; while the receiver stalls a full output, every
// stage holds and i_cmd.ready is low.
// Reset is synchronous: all stage valid bits clear and the three registers
// return to their default values.
`default_nettype none
module servo_linkage_angle_to_pulse_unit import slap_pkg::*; #(
    parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    slap_cmd_if.sink    i_cmd,
    slap_cfg_if.sink    i_cfg,
    slap_res_if.source  o_res
);
    localparam int N  = CORDIC_STAGES;
    localparam int DQ = QW;

    logic en;

    logic [15:0] r_x_gain, r_y_gain;
    logic [14:0] r_tilt_lim;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_gain   <= X_GAIN_RST;
            r_y_gain   <= Y_GAIN_RST;
            r_tilt_lim <= TILT_LIMIT_RST;
        end else if (i_cfg.valid) begin
            case (t_reg_idx'(i_cfg.index))
                REG_X_GAIN:     r_x_gain   <= i_cfg.data;
                REG_Y_GAIN:     r_y_gain   <= i_cfg.data;
                REG_TILT_LIMIT: r_tilt_lim <= i_cfg.data[14:0];
                default:        ;
            endcase
        end
    end

    // Stage A: clamp the request and pick the axis gain.
    logic                r_a_v;
    logic signed [15:0]  r_a_ang;
    t_side               r_a_sd;
    logic signed [16:0]  a_in, a_lim;
    logic signed [15:0]  n_a_ang;
    t_side               n_a_sd;

    always_comb begin
        a_in  = 17'(i_cmd.tilt_angle);
        a_lim = signed'({2'b00, r_tilt_lim});
        if (a_in > a_lim) begin
            n_a_ang = 16'(a_lim);
        end else if (a_in < -a_lim) begin
            n_a_ang = 16'(-a_lim);
        end else begin
            n_a_ang = i_cmd.tilt_angle;
        end
        n_a_sd      = '0;
        n_a_sd.ax   = i_cmd.opcode;
        n_a_sd.gain = i_cmd.opcode ? r_y_gain : r_x_gain;
    end

    // Stage B: degrees to radians.
    logic               r_b_v;
    logic signed [40:0] r_b_prod;
    t_side              r_b_sd;

    // Stage C: absolute arm angle and quarter-turn pre-rotation.
    logic                 r_rv  [0:N];
    logic signed [XW-1:0] r_rx  [0:N];
    logic signed [XW-1:0] r_ry  [0:N];
    logic signed [ZW-1:0] r_rz  [0:N];
    t_side                r_rsd [0:N];
    logic signed [ZW-1:0] c_t;
    logic signed [XW-1:0] c_r, n_c_x, n_c_y;
    logic signed [ZW-1:0] n_c_z;

    always_comb begin
        c_t   = alpha0(r_b_sd.ax) + ZW'(r_b_prod >>> 8);
        c_r   = rot_start(r_b_sd.ax);
        n_c_x = c_r;
        n_c_y = '0;
        n_c_z = c_t;
        if (c_t > HALF_PI_Q30) begin
            n_c_x = '0;
            n_c_y = c_r;
            n_c_z = c_t - HALF_PI_Q30;
        end else if (c_t < -HALF_PI_Q30) begin
            n_c_x = '0;
            n_c_y = -c_r;
            n_c_z = c_t + HALF_PI_Q30;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v    <= 1'b0;
            r_b_v    <= 1'b0;
            r_rv[0]  <= 1'b0;
        end else if (en) begin
            r_a_v    <= i_cmd.valid;
            r_b_v    <= r_a_v;
            r_rv[0]  <= r_b_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a_ang  <= n_a_ang;
            r_a_sd   <= n_a_sd;
            r_b_prod <= 41'(r_a_ang) * DEG2RAD_Q30;
            r_b_sd   <= r_a_sd;
            r_rx[0]  <= n_c_x;
            r_ry[0]  <= n_c_y;
            r_rz[0]  <= n_c_z;
            r_rsd[0] <= r_b_sd;
        end
    end

    // Rotation CORDIC, one iteration per stage.
    for (genvar k = 0; k < N; k++) begin : g_rot
        logic signed [XW-1:0] xs, ys, n_x, n_y;
        logic signed [ZW-1:0] n_z;

        always_comb begin
            xs = r_rx[k] >>> k;
            ys = r_ry[k] >>> k;
            if (r_rz[k] >= 0) begin
                n_x = r_rx[k] - ys;
                n_y = r_ry[k] + xs;
                n_z = r_rz[k] - atan_q30(k);
            end else begin
                n_x = r_rx[k] + ys;
                n_y = r_ry[k] - xs;
                n_z = r_rz[k] + atan_q30(k);
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_rv[k+1] <= 1'b0;
            end else if (en) begin
                r_rv[k+1] <= r_rv[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_rx[k+1]  <= n_x;
                r_ry[k+1]  <= n_y;
                r_rz[k+1]  <= n_z;
                r_rsd[k+1] <= r_rsd[k];
            end
        end
    end

    // Stages D, E, F: offset to the pivot, squares, squared length and numerator.
    logic                 r_d_v, r_e_v, r_f_v;
    t_side                r_d_sd, r_e_sd, r_f_sd;
    logic [SQ_W-1:0]      r_e_sqx, r_e_sqy, r_f_l4sq;
    t_side                n_d_sd, n_f_sd;
    logic [SQ_W-1:0]      f_sum;
    logic signed [55:0]   f_full;

    always_comb begin
        n_d_sd    = r_rsd[N];
        n_d_sd.dx = DW'(r_rx[N] - pivot_x(r_rsd[N].ax));
        n_d_sd.dy = DW'(r_ry[N] - pivot_y(r_rsd[N].ax));
        f_sum     = r_e_sqx + r_e_sqy;
        f_full    = signed'({2'b00, f_sum}) + num_k(r_e_sd.ax);
        n_f_sd     = r_e_sd;
        n_f_sd.num = NUMW'(f_full >>> 16);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_v <= 1'b0;
            r_e_v <= 1'b0;
            r_f_v <= 1'b0;
        end else if (en) begin
            r_d_v <= r_rv[N];
            r_e_v <= r_d_v;
            r_f_v <= r_e_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_d_sd   <= n_d_sd;
            r_e_sqx  <= SQ_W'(56'(r_d_sd.dx) * 56'(r_d_sd.dx));
            r_e_sqy  <= SQ_W'(56'(r_d_sd.dy) * 56'(r_d_sd.dy));
            r_e_sd   <= r_d_sd;
            r_f_l4sq <= f_sum;
            r_f_sd   <= n_f_sd;
        end
    end

    // Distance to the servo pivot.
    logic              l4_v;
    logic [SQ_W/2-1:0] l4_root;
    t_side             l4_sd;

    slap_isqrt #(.W(SQ_W)) u_len_root (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_f_v),
        .i_val   (r_f_l4sq),
        .i_side  (r_f_sd),
        .o_valid (l4_v),
        .o_root  (l4_root),
        .o_side  (l4_sd)
    );

    // Stage G: cosine denominator. Stage H: divider set-up.
    logic              r_g_v;
    logic [DENW-1:0]   r_g_den;
    t_side             r_g_sd;
    logic [48:0]       g_prod;
    logic [DENW-1:0]   n_g_den;
    logic [NUMW-1:0]   h_abs;
    logic [63:0]       h_n;
    logic              h_over;

    logic [63:0]       r_q_rem  [0:DQ];
    logic [QW-1:0]     r_q_q    [0:DQ];
    logic [DENW-1:0]   r_q_den  [0:DQ];
    logic              r_q_over [0:DQ];
    logic              r_q_neg  [0:DQ];
    logic              r_q_v    [0:DQ];
    t_side             r_q_sd   [0:DQ];

    always_comb begin
        g_prod  = 49'(l4_root) * 49'(TWO_L3);
        n_g_den = DENW'(g_prod >> 16);
        if (n_g_den == '0) begin
            n_g_den = DENW'(1);
        end
        h_abs  = (r_g_sd.num < 0) ? NUMW'(-r_g_sd.num) : NUMW'(r_g_sd.num);
        h_n    = {h_abs, 24'd0};
        h_over = (h_n >> QW) >= 64'(r_g_den);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_g_v      <= 1'b0;
            r_q_v[0]   <= 1'b0;
        end else if (en) begin
            r_g_v      <= l4_v;
            r_q_v[0]   <= r_g_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_g_den     <= n_g_den;
            r_g_sd      <= l4_sd;
            r_q_rem[0]  <= h_n;
            r_q_q[0]    <= '0;
            r_q_den[0]  <= r_g_den;
            r_q_over[0] <= h_over;
            r_q_neg[0]  <= r_g_sd.num < 0;
            r_q_sd[0]   <= r_g_sd;
        end
    end

    // Restoring divider, quotient bits from the top down, one per stage.
    for (genvar j = 0; j < DQ; j++) begin : g_div
        localparam int SH = DQ - 1 - j;
        logic [63:0]   n_rem;
        logic [QW-1:0] n_q;

        always_comb begin
            n_rem = r_q_rem[j];
            n_q   = r_q_q[j];
            if ((r_q_rem[j] >> SH) >= 64'(r_q_den[j])) begin
                n_rem = r_q_rem[j] - (64'(r_q_den[j]) << SH);
                n_q   = r_q_q[j] | (QW'(1) << SH);
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_q_v[j+1] <= 1'b0;
            end else if (en) begin
                r_q_v[j+1] <= r_q_v[j];
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_q_rem[j+1]  <= n_rem;
                r_q_q[j+1]    <= n_q;
                r_q_den[j+1]  <= r_q_den[j];
                r_q_over[j+1] <= r_q_over[j];
                r_q_neg[j+1]  <= r_q_neg[j];
                r_q_sd[j+1]   <= r_q_sd[j];
            end
        end
    end

    // Stage I: signed, saturated cosine. Stages J, K: 1 - c^2 for the sine.
    logic              r_i_v, r_j_v, r_k_v;
    t_side             r_i_sd, r_j_sd, r_k_sd;
    logic [SIN_W-1:0]  r_j_csq, r_k_val;
    logic [QW-1:0]     i_mag;
    t_side             n_i_sd;

    always_comb begin
        i_mag = r_q_q[DQ];
        if (r_q_over[DQ] || (r_q_q[DQ] > COS_ONE)) begin
            i_mag = COS_ONE;
        end
        n_i_sd   = r_q_sd[DQ];
        n_i_sd.c = r_q_neg[DQ] ? -CW'(i_mag) : CW'(i_mag);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_i_v <= 1'b0;
            r_j_v <= 1'b0;
            r_k_v <= 1'b0;
        end else if (en) begin
            r_i_v <= r_q_v[DQ];
            r_j_v <= r_i_v;
            r_k_v <= r_j_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_i_sd  <= n_i_sd;
            r_j_csq <= SIN_W'(52'(r_i_sd.c) * 52'(r_i_sd.c));
            r_j_sd  <= r_i_sd;
            r_k_val <= ONE_SQ - r_j_csq;
            r_k_sd  <= r_j_sd;
        end
    end

    logic               s_v;
    logic [SIN_W/2-1:0] s_root;
    t_side              s_sd;

    slap_isqrt #(.W(SIN_W)) u_sin_root (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_k_v),
        .i_val   (r_k_val),
        .i_side  (r_k_sd),
        .o_valid (s_v),
        .o_root  (s_root),
        .o_side  (s_sd)
    );

    // Law-of-cosines angle and pivot direction, side by side.
    logic                 v1_v;
    logic signed [ZW-1:0] v1_z, v2_z;
    t_side                v1_sd;

    slap_vec #(.N(N)) u_cos_angle (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (s_v),
        .i_x     (XW'(s_sd.c)),
        .i_y     (signed'(XW'(s_root))),
        .i_side  (s_sd),
        .o_valid (v1_v),
        .o_z     (v1_z),
        .o_side  (v1_sd)
    );

    slap_vec #(.N(N)) u_pivot_angle (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (s_v),
        .i_x     (-XW'(s_sd.dx)),
        .i_y     (-XW'(s_sd.dy)),
        .i_side  (s_sd),
        .o_valid (),
        .o_z     (v2_z),
        .o_side  ()
    );

    // Stages M, N, O: servo angle in degrees, gain, offset and saturation.
    logic               r_m_v, r_n_v, r_o_v;
    logic signed [57:0] r_m_prod;
    logic signed [44:0] r_n_p;
    t_side              r_m_sd, r_n_sd;
    logic               r_o_ax;
    logic [15:0]        r_o_pw;
    logic signed [34:0] m_diff;
    logic signed [27:0] n_deg;
    logic signed [46:0] o_sum;
    logic signed [22:0] o_pl;
    logic [15:0]        n_o_pw;

    always_comb begin
        m_diff = -35'(v2_z) - 35'(v1_z);
        n_deg  = 28'(r_m_prod >>> 30);
        o_sum  = CENTER_Q24 + 47'(r_n_p);
        o_pl   = 23'(o_sum >>> 24);
        if (o_pl < 0) begin
            n_o_pw = '0;
        end else if (o_pl > 23'sd65535) begin
            n_o_pw = 16'hFFFF;
        end else begin
            n_o_pw = o_pl[15:0];
        end
    end

    assign en          = !r_o_v || o_res.ready;
    assign i_cmd.ready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_v <= 1'b0;
            r_n_v <= 1'b0;
            r_o_v <= 1'b0;
        end else if (en) begin
            r_m_v <= v1_v;
            r_n_v <= r_m_v;
            r_o_v <= r_n_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_m_prod <= 58'(m_diff) * RAD2DEG_Q16;
            r_m_sd   <= v1_sd;
            r_n_p    <= 45'(n_deg) * 45'(signed'({1'b0, r_m_sd.gain}));
            r_n_sd   <= r_m_sd;
            r_o_pw   <= n_o_pw;
            r_o_ax   <= r_n_sd.ax;
        end
    end

    assign o_res.valid       = r_o_v;
    assign o_res.axis        = r_o_ax;
    assign o_res.pulse_width = r_o_pw;
endmodule
`default_nettype wire

// ----- rtl/slap_chk.sv -----
// Port-level checker for the servo linkage block, bound to the top level.
`default_nettype none
module slap_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_cmd_valid,
    input logic        i_cmd_ready,
    input logic        i_cfg_ready,
    input logic        i_res_valid,
    input logic        i_res_ready,
    input logic        i_res_axis,
    input logic [15:0] i_res_pw
);
    // A result that is not taken stays put.
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=>
            i_res_valid && $stable(i_res_pw) && $stable(i_res_axis))
        else $error("result changed while stalled");

    // Reset leaves no result in flight.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_res_valid)
        else $error("result valid right after reset");

    // A stalled output freezes the pipe, so no request may enter.
    a_stall_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |-> !i_cmd_ready)
        else $error("request accepted while output stalled");

    // With nothing waiting at the output, the block takes a request.
    a_free_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_res_valid && i_cmd_valid |-> i_cmd_ready && i_cfg_ready)
        else $error("request refused with empty output");
endmodule

bind servo_linkage_angle_to_pulse_unit slap_chk u_slap_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_cmd_valid (i_cmd.valid),
    .i_cmd_ready (i_cmd.ready),
    .i_cfg_ready (i_cfg.ready),
    .i_res_valid (o_res.valid),
    .i_res_ready (o_res.ready),
    .i_res_axis  (o_res.axis),
    .i_res_pw    (o_res.pulse_width)
);
`default_nettype wire
